FILE: rtl/ptsu_pkg.sv
// Shared types, codes and constants for the priority task table scheduler.
`timescale 1ns / 1ps
package ptsu_pkg;

  localparam int ID_W      = 16;
  localparam int CMD_W     = 4;
  localparam int PRIO_W    = 3;
  localparam int ST_W      = 3;
  localparam int BURST_W   = 32;
  localparam int QUANTUM_W = 16;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd1000;
  localparam logic [ID_W-1:0]      ID_FIRST      = 16'd1;
  localparam logic [ID_W-1:0]      ID_LAST       = 16'hFFFF;

  localparam logic [CMD_W-1:0] CMD_CREATE     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SET_STATE  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_PAUSE_ALL  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RESUME_ALL = 4'd5;
  localparam logic [CMD_W-1:0] CMD_STOP_ALL   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_TICK       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PICK       = 4'd8;

  localparam logic [ST_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [ST_W-1:0] ST_PAUSED    = 3'd1;
  localparam logic [ST_W-1:0] ST_STOPPED   = 3'd2;
  localparam logic [ST_W-1:0] ST_WAITING   = 3'd3;
  localparam logic [ST_W-1:0] ST_COMPLETED = 3'd4;

  localparam logic [PRIO_W-1:0] PRIO_LOW      = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_MEDIUM   = 3'd2;
  localparam logic [PRIO_W-1:0] PRIO_CRITICAL = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  // Out-of-range requests fall back to medium.
  function automatic logic [PRIO_W-1:0] legal_prio(input logic [PRIO_W-1:0] p);
    if (p >= PRIO_LOW && p <= PRIO_CRITICAL) begin
      return p;
    end
    return PRIO_MEDIUM;
  endfunction

endpackage

FILE: rtl/ptsu_table_ram.sv
// Task table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module ptsu_table_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 86,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/priority_thread_table_scheduler_unit.sv
// Top level: command sequencer that sweeps the task table memory per command.
// One command at a time: in_ready stays low from the accepted command until its result is
// registered. Every command reads each table entry once and writes back the used ones
// through the single-port-pair table memory.
// Reset (rst_n, synchronous, active low): table empty, next id 1, quantum 1000.
// Table contents are not cleared; the per-slot used bits gate every use of the read data.
`timescale 1ns / 1ps
module priority_thread_table_scheduler_unit #(
  parameter int MAX_TASKS  = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptsu_pkg::QUANTUM_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptsu_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ptsu_pkg::ID_W-1:0]      in_thread_id,
  input  logic [ptsu_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic [ptsu_pkg::ST_W-1:0]      in_new_state,
  input  logic [ptsu_pkg::BURST_W-1:0]   in_burst_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptsu_pkg::STATUS_W-1:0]  out_status,
  output logic [ptsu_pkg::ID_W-1:0]      out_result_id,
  output logic                          out_next_found,
  output logic [ptsu_pkg::CNT_OUT_W-1:0] out_total_count,
  output logic [ptsu_pkg::CNT_OUT_W-1:0] out_running_count,
  output logic [ptsu_pkg::CNT_OUT_W-1:0] out_completed_count
);
  import ptsu_pkg::*;

  localparam int IW    = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TW    = TIME_WIDTH;
  localparam int CW    = (TW > BURST_W) ? TW : BURST_W;
  localparam int EW    = ID_W + ST_W + PRIO_W + TW + BURST_W;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DONE} state_t;

  state_t               state_r;
  logic [QUANTUM_W-1:0] quantum_r;
  logic [ID_W-1:0]      next_id_r;
  logic [MAX_TASKS-1:0] slot_used_r;

  logic [CMD_W-1:0]     cmd_r;
  logic [ID_W-1:0]      tid_r;
  logic [PRIO_W-1:0]    prio_r;
  logic [ST_W-1:0]      nst_r;
  logic [BURST_W-1:0]   burst_r;

  logic [IW:0]          rd_cnt_r;
  logic                 proc_valid_r;
  logic [IW-1:0]        proc_idx_r;
  logic                 hit_r, hit_nxt;
  logic                 pf_r, pf_nxt;
  logic [PRIO_W-1:0]    best_pr_r, best_pr_nxt;
  logic [TW-1:0]        best_el_r, best_el_nxt;
  logic [ID_W-1:0]      best_id_r, best_id_nxt;
  logic [CNT_W-1:0]     tot_r, tot_nxt, run_r, run_nxt, cmp_r, cmp_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [ID_W-1:0]      rid_r;
  logic                 found_r;
  logic [CNT_OUT_W-1:0] otot_r, orun_r, ocmp_r;

  // Table memory
  logic          rd_en;
  logic [EW-1:0] rdata, wdata;
  logic          wr_en;

  ptsu_table_ram #(.DEPTH(MAX_TASKS), .WIDTH(EW), .ADDR_W(IW)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (proc_idx_r),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_cnt_r[IW-1:0]),
    .rdata (rdata)
  );

  assign rd_en = (state_r == S_SWEEP) && (rd_cnt_r != (IW+1)'(MAX_TASKS));

  // Entry fields as read and as modified
  logic [ID_W-1:0]   e_id, n_id;
  logic [ST_W-1:0]   e_st, n_st;
  logic [PRIO_W-1:0] e_pr, n_pr;
  logic [TW-1:0]     e_el, n_el, sat_el;
  logic [BURST_W-1:0] e_bu, n_bu;
  logic [TW:0]       sum_el;
  logic              used, n_used, better;
  logic [CW-1:0]     el_ext, bu_ext;

  assign e_bu = rdata[BURST_W-1:0];
  assign e_el = rdata[BURST_W +: TW];
  assign e_pr = rdata[BURST_W+TW +: PRIO_W];
  assign e_st = rdata[BURST_W+TW+PRIO_W +: ST_W];
  assign e_id = rdata[BURST_W+TW+PRIO_W+ST_W +: ID_W];

  assign sum_el = {1'b0, e_el} + (TW+1)'(quantum_r);
  assign sat_el = sum_el[TW] ? {TW{1'b1}} : sum_el[TW-1:0];
  assign el_ext = CW'(sat_el);
  assign bu_ext = CW'(e_bu);
  assign wdata  = {n_id, n_st, n_pr, n_el, n_bu};

  always_comb begin
    used    = slot_used_r[proc_idx_r];
    n_used  = used;
    n_id    = e_id;
    n_st    = e_st;
    n_pr    = e_pr;
    n_el    = e_el;
    n_bu    = e_bu;
    // clear the sweep accumulators while idle
    hit_nxt = (state_r == S_IDLE) ? 1'b0 : hit_r;
    if (proc_valid_r) begin
      case (cmd_r) inside
        CMD_CREATE: begin
          if (!used && !hit_r) begin
            n_used  = 1'b1;
            n_id    = next_id_r;
            n_st    = ST_RUNNING;
            n_pr    = prio_r;
            n_el    = '0;
            n_bu    = burst_r;
            hit_nxt = 1'b1;
          end
        end
        CMD_DELETE, CMD_SET_STATE, CMD_SET_PRIO: begin
          // act on the lowest matching slot only
          if (used && !hit_r && e_id == tid_r) begin
            hit_nxt = 1'b1;
            if (cmd_r == CMD_DELETE) begin
              n_used = 1'b0;
            end else if (cmd_r == CMD_SET_STATE) begin
              if (nst_r <= ST_COMPLETED) begin
                n_st = nst_r;
              end
            end else begin
              n_pr = prio_r;
            end
          end
        end
        CMD_PAUSE_ALL: begin
          if (used && e_st == ST_RUNNING) n_st = ST_PAUSED;
        end
        CMD_RESUME_ALL: begin
          if (used && e_st == ST_PAUSED) n_st = ST_RUNNING;
        end
        CMD_STOP_ALL: begin
          if (used && e_st != ST_COMPLETED) n_st = ST_STOPPED;
        end
        CMD_TICK: begin
          if (used && e_st == ST_RUNNING) begin
            n_el = sat_el;
            if (el_ext >= bu_ext) n_st = ST_COMPLETED;
          end
        end
        default: begin
        end
      endcase
    end
    wr_en = proc_valid_r && n_used;

    tot_nxt = (state_r == S_IDLE) ? '0 : tot_r;
    run_nxt = (state_r == S_IDLE) ? '0 : run_r;
    cmp_nxt = (state_r == S_IDLE) ? '0 : cmp_r;
    if (proc_valid_r && n_used) begin
      tot_nxt = tot_r + CNT_W'(1);
      if (n_st == ST_RUNNING)   run_nxt = run_r + CNT_W'(1);
      if (n_st == ST_COMPLETED) cmp_nxt = cmp_r + CNT_W'(1);
    end

    better = !pf_r || (n_pr > best_pr_r) ||
             (n_pr == best_pr_r && (n_el < best_el_r ||
                                    (n_el == best_el_r && n_id < best_id_r)));
    pf_nxt      = (state_r == S_IDLE) ? 1'b0 : pf_r;
    best_pr_nxt = best_pr_r;
    best_el_nxt = best_el_r;
    best_id_nxt = best_id_r;
    if (proc_valid_r && cmd_r == CMD_PICK && n_used && n_st == ST_RUNNING && better) begin
      pf_nxt      = 1'b1;
      best_pr_nxt = n_pr;
      best_el_nxt = n_el;
      best_id_nxt = n_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      quantum_r    <= QUANTUM_RESET;
      next_id_r    <= ID_FIRST;
      slot_used_r  <= '0;
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_cnt_r     <= '0;
      hit_r        <= 1'b0;
      pf_r         <= 1'b0;
      tot_r        <= '0;
      run_r        <= '0;
      cmp_r        <= '0;
    end else begin
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      // drop a taken result unless a new one replaces it this cycle
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (proc_valid_r) begin
        slot_used_r[proc_idx_r] <= n_used;
      end
      hit_r     <= hit_nxt;
      pf_r      <= pf_nxt;
      best_pr_r <= best_pr_nxt;
      best_el_r <= best_el_nxt;
      best_id_r <= best_id_nxt;
      tot_r     <= tot_nxt;
      run_r     <= run_nxt;
      cmp_r     <= cmp_nxt;

      unique case (state_r)
        S_IDLE: begin
          proc_valid_r <= 1'b0;
          if (in_valid) begin
            cmd_r    <= in_cmd;
            tid_r    <= in_thread_id;
            prio_r   <= legal_prio(in_priority_req);
            nst_r    <= in_new_state;
            burst_r  <= in_burst_time;
            rd_cnt_r <= '0;
            state_r  <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          proc_valid_r <= rd_en;
          proc_idx_r   <= rd_cnt_r[IW-1:0];
          if (rd_en) begin
            rd_cnt_r <= rd_cnt_r + (IW+1)'(1);
          end
          if (proc_valid_r && proc_idx_r == IW'(MAX_TASKS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          proc_valid_r <= 1'b0;
          if (!out_valid_r || out_ready) begin
            status_r <= STAT_OK;
            rid_r    <= '0;
            found_r  <= 1'b0;
            if (cmd_r == CMD_CREATE) begin
              if (hit_r) begin
                rid_r     <= next_id_r;
                next_id_r <= (next_id_r == ID_LAST) ? ID_FIRST : next_id_r + ID_W'(1);
              end else begin
                status_r <= STAT_FULL;
              end
            end else if (cmd_r == CMD_DELETE || cmd_r == CMD_SET_STATE ||
                         cmd_r == CMD_SET_PRIO) begin
              if (!hit_r) status_r <= STAT_NOT_FOUND;
            end else if (cmd_r == CMD_PICK && pf_r) begin
              found_r <= 1'b1;
              rid_r   <= best_id_r;
            end
            otot_r      <= CNT_OUT_W'(tot_r);
            orun_r      <= CNT_OUT_W'(run_r);
            ocmp_r      <= CNT_OUT_W'(cmp_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_result_id       = rid_r;
  assign out_next_found      = found_r;
  assign out_total_count     = otot_r;
  assign out_running_count   = orun_r;
  assign out_completed_count = ocmp_r;

`ifndef SYNTHESIS
  a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0) else $error("next id reached zero");

  a_counts_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> ({1'b0, run_r} + {1'b0, cmp_r}) <= {1'b0, tot_r})
    else $error("state counts exceed task count");

  a_found_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_r |-> status_r == STAT_OK && rid_r != '0)
    else $error("pick result carries bad status or id");

  a_no_read_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !rd_en && !wr_en)
    else $error("table access outside sweep");
`endif

endmodule
